@@ rtl/decimal_digit_emitter_core_assert.svh @@
// assertion macros shared by the checker of the decimal digit emitter
// depends on nothing; included by the checker file
`ifndef DECIMAL_DIGIT_EMITTER_CORE_ASSERT_SVH
`define DECIMAL_DIGIT_EMITTER_CORE_ASSERT_SVH

// clocked property, ignored while reset is high
`define DDE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("decimal digit emitter check failed");

// clocked property that also holds across reset
`define DDE_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("decimal digit emitter check failed");

`endif

@@ rtl/ddemit_pkg.sv @@
// types, constants and the double-dabble step of the decimal digit emitter
// depends on nothing
`default_nettype none
package ddemit_pkg;

   localparam int NUM_BCD   = 10;
   localparam int DIGIT_W   = 4;
   localparam int BCD_W     = NUM_BCD * DIGIT_W;
   localparam int VALUE_W   = 32;
   localparam int NUM_STAGE = 4;
   localparam int STEPS     = VALUE_W / NUM_STAGE;
   localparam int POS_W     = 11;

   localparam logic [9:0]       START_X_RST = 10'h2f;
   localparam logic [5:0]       STEP_X_RST  = 6'hf;
   localparam logic [7:0]       GLYPH_RST   = 8'h1c;
   localparam logic [POS_W-1:0] POS_MAX     = 11'h7ff;

   typedef enum logic [1:0] {
      CSR_START_X    = 2'd0,
      CSR_STEP_X     = 2'd1,
      CSR_GLYPH_BASE = 2'd2,
      CSR_NONE       = 2'd3
   } csr_index_type;

   typedef logic [BCD_W-1:0] bcd_type;

   // one double-dabble step: correct every digit then shift in a bit
   function automatic bcd_type dabble_step(input bcd_type bcd, input logic b);
      bcd_type t;
      t = bcd;
      for (int i = 0; i < NUM_BCD; i++) begin
         if (t[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
            t[i*DIGIT_W +: DIGIT_W] = t[i*DIGIT_W +: DIGIT_W] + 4'd3;
         end
      end
      return {t[BCD_W-2:0], b};
   endfunction

endpackage
`default_nettype wire

@@ rtl/decimal_digit_emitter_core.sv @@
// top level of the decimal digit emitter: double-dabble pipeline and digit emitter
// depends on ddemit_pkg
//
//  channel | direction | handshake        | payload
//  req     | in        | valid / stall    | value
//  rsp     | out       | valid / stall    | digit, glyph, pos_x, last
//  csr     | in        | valid / ready    | index, data
//
// a value enters every cycle while the pipeline has room; four register
// stages do eight double-dabble shifts each, and the last one loads the
// emitter register, which then sends one digit per cycle while rsp is not
// stalled, so an item sends 1 to CAP digits (its digit count, capped at CAP).
// reset is synchronous and clears all valid bits and the configuration registers.
// a stall on rsp backs up stage by stage; nothing is dropped or repeated.
`default_nettype none
module decimal_digit_emitter_core
   import ddemit_pkg::*;
#(
   parameter int MAX_DIGITS = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_digit,
   output logic [7:0]       rsp_glyph,
   output logic [10:0]      rsp_pos_x,
   output logic             rsp_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [9:0]  csr_data
);

   // digits actually kept per item
   localparam int CAP   = (MAX_DIGITS < NUM_BCD) ? MAX_DIGITS : NUM_BCD;
   localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
   localparam logic [3:0] CAP_LAST = 4'(CAP - 1);

   // configuration registers
   logic [9:0] start_x_ff;
   logic [5:0] step_x_ff;
   logic [7:0] glyph_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= START_X_RST;
         step_x_ff  <= STEP_X_RST;
         glyph_ff   <= GLYPH_RST;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_START_X:    start_x_ff <= csr_data;
            CSR_STEP_X:     step_x_ff  <= csr_data[5:0];
            CSR_GLYPH_BASE: glyph_ff   <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // conversion pipeline
   logic                 stg_v_ff   [NUM_STAGE];
   bcd_type              stg_bcd_ff [NUM_STAGE];
   logic [VALUE_W-1:0]   stg_bin_ff [NUM_STAGE];
   bcd_type              stg_bcd_in [NUM_STAGE];
   logic [VALUE_W-1:0]   stg_bin_in [NUM_STAGE];
   logic                 stg_ld     [NUM_STAGE];

   // emitter
   logic                 em_v_ff;
   logic [DIGIT_W-1:0]   em_dig_ff [CAP];
   logic [IDX_W-1:0]     em_idx_ff;
   logic [POS_W-1:0]     em_pos_ff;
   logic                 em_ld;
   logic                 rsp_fire;
   logic [3:0]           top_hi;
   logic [POS_W:0]       pos_sum;

   assign rsp_fire = em_v_ff && !rsp_stall;
   assign em_ld    = !em_v_ff || (rsp_fire && (em_idx_ff == '0));

   // a stage loads when empty or when the next one takes its word
   always_comb begin
      stg_ld[NUM_STAGE-1] = !stg_v_ff[NUM_STAGE-1] || em_ld;
      for (int s = NUM_STAGE - 2; s >= 0; s--) begin
         stg_ld[s] = !stg_v_ff[s] || stg_ld[s+1];
      end
   end

   assign req_stall = !stg_ld[0];

   // eight dabble steps per stage
   always_comb begin
      for (int s = 0; s < NUM_STAGE; s++) begin
         bcd_type            b;
         logic [VALUE_W-1:0] n;
         if (s == 0) begin
            b = '0;
            n = req_value;
         end else begin
            b = stg_bcd_ff[s-1];
            n = stg_bin_ff[s-1];
         end
         for (int k = 0; k < STEPS; k++) begin
            b = dabble_step(b, n[VALUE_W-1]);
            n = {n[VALUE_W-2:0], 1'b0};
         end
         stg_bcd_in[s] = b;
         stg_bin_in[s] = n;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NUM_STAGE; s++) begin
         if (reset) begin
            stg_v_ff[s] <= 1'b0;
         end else if (stg_ld[s]) begin
            stg_v_ff[s] <= (s == 0) ? req_valid : stg_v_ff[(s == 0) ? 0 : s-1];
         end
         if (stg_ld[s]) begin
            stg_bcd_ff[s] <= stg_bcd_in[s];
            stg_bin_ff[s] <= stg_bin_in[s];
         end
      end
   end

   // highest non-zero digit; zero counts as one digit
   always_comb begin
      top_hi = '0;
      for (int i = 0; i < NUM_BCD; i++) begin
         if (stg_bcd_ff[NUM_STAGE-1][i*DIGIT_W +: DIGIT_W] != '0) begin
            top_hi = 4'(i);
         end
      end
      if (top_hi > CAP_LAST) begin
         top_hi = CAP_LAST;
      end
   end

   // next position, saturating at the field maximum
   assign pos_sum = {1'b0, em_pos_ff} + (POS_W+1)'(step_x_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         em_v_ff <= 1'b0;
      end else if (em_ld) begin
         em_v_ff <= stg_v_ff[NUM_STAGE-1];
      end
      if (em_ld) begin
         for (int i = 0; i < CAP; i++) begin
            em_dig_ff[i] <= stg_bcd_ff[NUM_STAGE-1][i*DIGIT_W +: DIGIT_W];
         end
         em_idx_ff <= IDX_W'(top_hi);
         em_pos_ff <= POS_W'(start_x_ff);
      end else if (rsp_fire) begin
         // step to the next lower digit
         em_idx_ff <= em_idx_ff - 1'b1;
         em_pos_ff <= pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
      end
   end

   assign rsp_valid = em_v_ff;
   assign rsp_digit = em_dig_ff[em_idx_ff];
   assign rsp_glyph = glyph_ff + 8'(rsp_digit);
   assign rsp_pos_x = em_pos_ff;
   assign rsp_last  = (em_idx_ff == '0);

endmodule
`default_nettype wire

@@ rtl/ddemit_checker.sv @@
// port-level checker of the decimal digit emitter and its bind
// depends on decimal_digit_emitter_core_assert.svh
`default_nettype none
`include "decimal_digit_emitter_core_assert.svh"
module ddemit_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [3:0]  rsp_digit,
   input wire logic [10:0] rsp_pos_x,
   input wire logic        rsp_last
);

   // a stalled word holds
   `DDE_ASSERT(a_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_digit))
   // digits are decimal
   `DDE_ASSERT(a_dec, clock, reset, rsp_valid |-> rsp_digit <= 4'd9)
   // a run continues straight away until its last digit
   `DDE_ASSERT(a_run, clock, reset, rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid && rsp_pos_x >= $past(rsp_pos_x))
   // nothing shows right after reset
   `DDE_ASSERT_ALWAYS(a_rst, clock, reset |=> !rsp_valid)

endmodule

bind decimal_digit_emitter_core ddemit_checker u_ddemit_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_digit (rsp_digit),
   .rsp_pos_x (rsp_pos_x),
   .rsp_last  (rsp_last)
);
`default_nettype wire
